[hdl/assert_macros.svh]
// assertion macros shared by the base64 line-wrap encoder rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define B64W_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define B64W_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define B64W_ASSERT(label, clk, rst_n, prop, msg)
`define B64W_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hdl/b64w_pkg.sv]
// constants, group word type and alphabet function for the base64 encoder
// no dependencies
`default_nettype none
package b64w_pkg;

  localparam int LINE_CHARS  = 64;
  localparam int LINE_SPAN   = (LINE_CHARS < 4) ? 4 : (LINE_CHARS / 4 * 4);
  localparam int LEN_W       = $clog2(LINE_SPAN);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [6:0] SEXTET_PAD = 7'd64;

  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       have2;
    logic       have3;
    logic       last;
  } group_t;

  function automatic logic [7:0] b64_char(input logic [6:0] s);
    logic [7:0] c;
    if (s < 7'd26) begin
      c = 8'h41 + {1'b0, s};
    end else if (s < 7'd52) begin
      c = 8'h47 + {1'b0, s};
    end else if (s < 7'd62) begin
      c = {1'b0, s} - 8'd4;
    end else if (s == 7'd62) begin
      c = 8'h2B;
    end else if (s == 7'd63) begin
      c = 8'h2F;
    end else begin
      c = CHAR_PAD;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hdl/b64w_if.sv]
// valid/ready channel interfaces for byte input and character output
// no dependencies
`default_nettype none
interface b64w_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64w_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_end;
  modport source(output valid, output out_char, output run_last, output message_end,
                 input ready);
  modport sink(input valid, input out_char, input run_last, input message_end,
               output ready);
endinterface
`default_nettype wire

[hdl/b64w_front.sv]
// front end: gathers bytes into 3-byte groups (shorter at the last byte) and pushes group words
// depends on b64w_pkg and b64w_if
`default_nettype none
module b64w_front
  import b64w_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  b64w_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       push,
  output group_t     push_word
);

  logic [1:0] gp_r, gp_nxt;
  logic [7:0] b1_r, b1_nxt;
  logic [7:0] b2_r, b2_nxt;
  logic       acc;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;

  always_comb begin
    gp_nxt    = gp_r;
    b1_nxt    = b1_r;
    b2_nxt    = b2_r;
    push      = 1'b0;
    push_word = '0;
    if (acc) begin
      unique case (gp_r)
        2'd0: begin
          b1_nxt         = in_ch.data_byte;
          push_word.b1   = in_ch.data_byte;
          push_word.last = in_ch.last_byte;
          push           = in_ch.last_byte;
          gp_nxt         = in_ch.last_byte ? 2'd0 : 2'd1;
        end
        2'd1: begin
          b2_nxt          = in_ch.data_byte;
          push_word.b1    = b1_r;
          push_word.b2    = in_ch.data_byte;
          push_word.have2 = 1'b1;
          push_word.last  = in_ch.last_byte;
          push            = in_ch.last_byte;
          gp_nxt          = in_ch.last_byte ? 2'd0 : 2'd2;
        end
        default: begin
          push_word.b1    = b1_r;
          push_word.b2    = b2_r;
          push_word.b3    = in_ch.data_byte;
          push_word.have2 = 1'b1;
          push_word.have3 = 1'b1;
          push_word.last  = in_ch.last_byte;
          push            = 1'b1;
          gp_nxt          = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r <= 2'd0;
    end else begin
      gp_r <= gp_nxt;
    end
    b1_r <= b1_nxt;
    b2_r <= b2_nxt;
  end

endmodule
`default_nettype wire

[hdl/b64w_queue.sv]
// short register queue of group words between front and back
// depends on b64w_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module b64w_queue
  import b64w_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  group_t push_word,
  input  logic   pop,
  output logic   head_valid,
  output group_t head_word,
  output logic   full
);

  group_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign head_valid = (count_r != '0);
  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_word  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  `B64W_NEVER(a_push_when_full, clk, rst_n, push && full, "push into full queue")
  `B64W_NEVER(a_pop_when_empty, clk, rst_n, pop && !head_valid, "pop from empty queue")

endmodule
`default_nettype wire

[hdl/b64w_back.sv]
// back end: turns group words into characters with padding and line breaks
// depends on b64w_pkg, b64w_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module b64w_back
  import b64w_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wrap_en,
  input  logic       head_valid,
  input  group_t     head_word,
  output logic       pop,
  b64w_out_if.source out_ch
);

  localparam logic [1:0] PH_CHAR = 2'd0;
  localparam logic [1:0] PH_CR   = 2'd1;
  localparam logic [1:0] PH_LF   = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_run_last_r, out_run_last_nxt;
  logic       out_message_end_r, out_message_end_nxt;

  logic       adv;
  logic       fin;
  logic       brk;
  logic       endbrk;
  logic [6:0] sext;
  logic [7:0] b1, b2, b3;

  assign adv = !out_valid_r || out_ch.ready;
  assign b1  = head_word.b1;
  assign b2  = head_word.b2;
  assign b3  = head_word.b3;
  assign brk = wrap_en && (len_r == LEN_W'(LINE_SPAN - 1));
  assign endbrk = (k_r == 2'd3) && !brk && head_word.last && wrap_en &&
                  ((len_r + 1'b1) != '0);

  always_comb begin
    unique case (k_r)
      2'd0: sext = {1'b0, b1[7:2]};
      2'd1: sext = {1'b0, b1[1:0], b2[7:4]};
      2'd2: sext = head_word.have2 ? {1'b0, b2[3:0], b3[7:6]} : SEXTET_PAD;
      default: sext = head_word.have3 ? {1'b0, b3[5:0]} : SEXTET_PAD;
    endcase
  end

  always_comb begin
    phase_nxt           = phase_r;
    k_nxt               = k_r;
    len_nxt             = len_r;
    fin                 = 1'b0;
    out_valid_nxt       = out_valid_r;
    out_char_nxt        = out_char_r;
    out_run_last_nxt    = out_run_last_r;
    out_message_end_nxt = out_message_end_r;
    if (adv) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        unique case (phase_r)
          PH_CHAR: begin
            out_char_nxt = b64_char(sext);
            len_nxt = (!wrap_en || brk || endbrk) ? '0 : len_r + 1'b1;
            if (brk || endbrk) begin
              phase_nxt = PH_CR;
            end else if (k_r == 2'd3) begin
              fin   = 1'b1;
              k_nxt = 2'd0;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
          PH_CR: begin
            out_char_nxt = CHAR_CR;
            phase_nxt    = PH_LF;
          end
          default: begin
            out_char_nxt = CHAR_LF;
            phase_nxt    = PH_CHAR;
            if (k_r == 2'd3) begin
              fin   = 1'b1;
              k_nxt = 2'd0;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        endcase
        out_run_last_nxt    = fin;
        out_message_end_nxt = fin && head_word.last;
      end
    end
  end

  assign pop = fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CHAR;
      k_r         <= 2'd0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r        <= out_char_nxt;
    out_run_last_r    <= out_run_last_nxt;
    out_message_end_r <= out_message_end_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.run_last    = out_run_last_r;
  assign out_ch.message_end = out_message_end_r;

  `B64W_ASSERT(a_end_is_run_last, clk, rst_n, out_valid_r && out_message_end_r |-> out_run_last_r, "message end without run last")
  `B64W_ASSERT(a_break_keeps_head, clk, rst_n, (phase_r != PH_CHAR) |-> head_valid, "line break without group")

endmodule
`default_nettype wire

[hdl/base64_encoder_line_wrap_core.sv]
// base64 encoder with optional crlf line wrap: one byte per cycle accepted while the
// group queue has room, one character per cycle delivered by the back end while
// out_ch.ready allows; a closed group is written to the queue, then its characters to
// the output register; a group yields four characters, plus cr and lf at a line break
// reset: synchronous active-low rst_n clears group, line count, queue and wrap
`default_nettype none
module base64_encoder_line_wrap_core
  import b64w_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  b64w_in_if.sink    in_ch,
  b64w_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic   wrap_en_r;
  logic   push;
  group_t push_word;
  logic   pop;
  logic   head_valid;
  group_t head_word;
  logic   q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      wrap_en_r <= cfg_wr_data;
    end
  end

  b64w_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  b64w_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word),
    .full       (q_full)
  );

  b64w_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wrap_en    (wrap_en_r),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
